@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files of the YUYV to BGR converter.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define Y2B_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("y2b assertion failed in the same cycle");

// Check that a condition implies a consequence in the following cycle.
`define Y2B_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("y2b assertion failed in the following cycle");

`endif

@@ rtl/core/y2b_pkg.sv @@
// Package of the YUYV to BGR converter: payload types, control bundle,
// register indices and the shared clamp and clip functions. No dependencies.
`timescale 1ns / 1ps

package y2b_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CNT_W      = 12;

  // Register indices on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [CFG_DATA_W-1:0] RST_LINE_STRIDE  = 13'd320;
  localparam logic [CFG_DATA_W-1:0] COUNT_LIMIT      = 13'd4096;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } in_item_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       line_end;
    logic       frame_end;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Per-word position flags from the raster counters
  typedef struct packed {
    logic visible;
    logic two_px;
    logic end0;
    logic end1;
    logic last_row;
  } word_ctrl_t;

  // Map zero to one and saturate above the limit
  function automatic logic [CFG_DATA_W-1:0] clamp_reg(input logic [CFG_DATA_W-1:0] v,
                                                      input logic [CFG_DATA_W-1:0] hi);
    logic [CFG_DATA_W-1:0] r;
    if (v == '0) begin
      r = 13'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Clip a signed channel value to 0..255
  function automatic logic [7:0] clip8(input logic signed [19:0] v);
    logic [7:0] r;
    if (v < 20'sd0) begin
      r = 8'd0;
    end else if (v > 20'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/y2b_lane.sv @@
// One conversion lane: a single YUV pixel to clipped BGR with BT.601
// studio-range integer coefficients. Depends on y2b_pkg.
`timescale 1ns / 1ps

module y2b_lane (
  input  logic [7:0]      luma_i,
  input  logic [7:0]      chroma_b_i,
  input  logic [7:0]      chroma_r_i,
  output y2b_pkg::pixel_t pixel_o
);
  import y2b_pkg::*;

  logic signed [19:0] c_s, d_s, e_s;
  logic signed [19:0] luma_term_s;
  logic signed [19:0] r_sum_s, g_sum_s, b_sum_s;

  // Remove the offsets
  assign c_s = $signed({12'd0, luma_i}) - 20'sd16;
  assign d_s = $signed({12'd0, chroma_b_i}) - 20'sd128;
  assign e_s = $signed({12'd0, chroma_r_i}) - 20'sd128;

  // Weighted sums with rounding
  assign luma_term_s = 20'sd298 * c_s + 20'sd128;
  assign r_sum_s = luma_term_s + 20'sd409 * e_s;
  assign g_sum_s = luma_term_s - 20'sd100 * d_s - 20'sd208 * e_s;
  assign b_sum_s = luma_term_s + 20'sd516 * d_s;

  // Floor shift and clip
  assign pixel_o.red   = clip8(r_sum_s >>> 8);
  assign pixel_o.green = clip8(g_sum_s >>> 8);
  assign pixel_o.blue  = clip8(b_sum_s >>> 8);

endmodule

@@ rtl/core/y2b_ctrl.sv @@
// Configuration registers and raster counters of the YUYV to BGR converter;
// flags each word as visible or padding and marks line and frame ends.
// Depends on y2b_pkg.
`timescale 1ns / 1ps

module y2b_ctrl #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [y2b_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [y2b_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             advance_i,
  output y2b_pkg::word_ctrl_t              ctrl_o
);
  import y2b_pkg::*;

  localparam int unsigned WIDTH_LIMIT = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam logic [CFG_DATA_W-1:0] WLIM = CFG_DATA_W'(WIDTH_LIMIT);

  logic [CFG_DATA_W-1:0] width_q, height_q, stride_q;
  logic [CNT_W-1:0]      col_q, col_d, row_q, row_d;

  logic [CFG_DATA_W-1:0] width_eff, height_eff, stride_eff, width_cut, vis_words;
  logic [CFG_DATA_W:0]   stride2;
  logic [CFG_DATA_W-1:0] px0, px1, width_m1;
  logic                  col_wrap, row_wrap;

  // Write the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_FRAME_WIDTH;
      height_q <= RST_FRAME_HEIGHT;
      stride_q <= RST_LINE_STRIDE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        CFG_LINE_STRIDE:  stride_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective geometry
  assign stride_eff = clamp_reg(stride_q, COUNT_LIMIT);
  assign height_eff = clamp_reg(height_q, COUNT_LIMIT);
  assign width_eff  = clamp_reg(width_q, WLIM);
  assign stride2    = {stride_eff, 1'b0};
  assign width_cut  = ({1'b0, width_eff} > stride2) ? stride2[CFG_DATA_W-1:0] : width_eff;
  assign vis_words  = CFG_DATA_W'(({1'b0, width_cut} + 14'd1) >> 1);
  assign width_m1   = width_cut - 13'd1;

  // Pixel positions of this word
  assign px0 = {col_q, 1'b0};
  assign px1 = px0 + 13'd1;

  assign ctrl_o.visible  = {1'b0, col_q} < vis_words;
  assign ctrl_o.two_px   = px1 < width_cut;
  assign ctrl_o.end0     = px0 == width_m1;
  assign ctrl_o.end1     = px1 == width_m1;
  assign ctrl_o.last_row = {1'b0, row_q} == (height_eff - 13'd1);

  // Advance the column and row after each word
  assign col_wrap = ({1'b0, col_q} + 13'd1) >= stride_eff;
  assign row_wrap = ({1'b0, row_q} + 13'd1) >= height_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + 12'd1;
      end else begin
        col_d = col_q + 12'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

@@ rtl/core/y2b_merge.sv @@
// Merging stage: captures both lane results of a word with their flags and
// hands them out one pixel per transfer. Depends on y2b_pkg.
`timescale 1ns / 1ps

module y2b_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  y2b_pkg::word_ctrl_t   ctrl_i,
  input  y2b_pkg::pixel_t       pix0_i,
  input  y2b_pkg::pixel_t       pix1_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output y2b_pkg::out_item_t    out_item_o,
  output logic                  free_o
);
  import y2b_pkg::*;

  logic      valid_q, valid_d;
  logic      sel_q, sel_d;
  logic      two_q;
  out_item_t px0_q, px1_q;
  logic      out_xfer, last_xfer;

  assign out_xfer  = valid_q && !out_stall_i;
  assign last_xfer = out_xfer && (sel_q || !two_q);
  assign free_o    = !valid_q || last_xfer;

  // Slot occupancy and pixel select
  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    if (last_xfer) begin
      valid_d = 1'b0;
      sel_d   = 1'b0;
    end else if (out_xfer) begin
      sel_d = 1'b1;
    end
    if (load_i) begin
      valid_d = 1'b1;
      sel_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  // Capture both pixels of the word
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      two_q           <= ctrl_i.two_px;
      px0_q.blue      <= pix0_i.blue;
      px0_q.green     <= pix0_i.green;
      px0_q.red       <= pix0_i.red;
      px0_q.line_end  <= ctrl_i.end0;
      px0_q.frame_end <= ctrl_i.end0 && ctrl_i.last_row;
      px0_q.run_last  <= !ctrl_i.two_px;
      px1_q.blue      <= pix1_i.blue;
      px1_q.green     <= pix1_i.green;
      px1_q.red       <= pix1_i.red;
      px1_q.line_end  <= ctrl_i.end1;
      px1_q.frame_end <= ctrl_i.end1 && ctrl_i.last_row;
      px1_q.run_last  <= 1'b1;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = sel_q ? px1_q : px0_q;

endmodule

@@ rtl/core/yuyv_to_bgr_stream_converter_top.sv @@
// YUYV to BGR stream converter, top level.
// Takes one YUYV word per input transfer (in_valid_i / in_stall_o with
// in_item_i) and gives BGR pixels one per output transfer (out_valid_o /
// out_stall_i with out_item_o). Padding words past the visible part of a
// line are taken and dropped. Frame geometry is written through the
// cfg_valid_i / cfg_ready_o port (index 0 width, 1 height, 2 stride);
// cfg_ready_o is always high; the user must make writes only while the
// stream is idle, which the block does not enforce. The first pixel of a
// word is registered and offered in the cycle after its transfer. Two
// visible pixels of a word go out in turn, a single one alone, and padding
// emits nothing; the single-pixel output port sets the pace. The next word
// is taken in the cycle the last pixel of the previous one leaves.
// When the receiver stalls, the offered pixel holds and input stalls once the
// output slot is full. Reset clears the counters, empties the output slot and
// loads width 640, height 480, stride 320. Depends on y2b_pkg.
`timescale 1ns / 1ps

module yuyv_to_bgr_stream_converter_top #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  y2b_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output y2b_pkg::out_item_t             out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [y2b_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [y2b_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import y2b_pkg::*;

  word_ctrl_t word_ctrl;
  pixel_t     pix0, pix1;
  logic       in_xfer, slot_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !slot_free;
  assign in_xfer     = in_valid_i && !in_stall_o;

  // Raster position and geometry
  y2b_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (in_xfer),
    .ctrl_o      (word_ctrl)
  );

  // Even pixel lane
  y2b_lane u_lane0 (
    .luma_i     (in_item_i.luma_first),
    .chroma_b_i (in_item_i.chroma_blue),
    .chroma_r_i (in_item_i.chroma_red),
    .pixel_o    (pix0)
  );

  // Odd pixel lane
  y2b_lane u_lane1 (
    .luma_i     (in_item_i.luma_second),
    .chroma_b_i (in_item_i.chroma_blue),
    .chroma_r_i (in_item_i.chroma_red),
    .pixel_o    (pix1)
  );

  // Merge both lanes onto the output
  y2b_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_xfer && word_ctrl.visible),
    .ctrl_i      (word_ctrl),
    .pix0_i      (pix0),
    .pix1_i      (pix1),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .free_o      (slot_free)
  );

endmodule

@@ rtl/core/y2b_checker.sv @@
// Port checker of the YUYV to BGR converter and its bind to the top level.
// Depends on y2b_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module y2b_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input y2b_pkg::out_item_t out_item_o
);
  import y2b_pkg::*;

  // A stalled pixel holds
  `Y2B_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  // An empty output never stalls the input
  `Y2B_ASSERT_SAME(a_no_stall_empty, clk_i, rst_ni, !out_valid_o, !in_stall_o)

  // The second pixel of a word follows the first at once
  `Y2B_ASSERT_NEXT(a_pair_follows, clk_i, rst_ni, out_valid_o && !out_stall_i && !out_item_o.run_last, out_valid_o)

  // A frame end is also a line end
  `Y2B_ASSERT_SAME(a_frame_is_line, clk_i, rst_ni, out_valid_o && out_item_o.frame_end, out_item_o.line_end)

endmodule

bind yuyv_to_bgr_stream_converter_top y2b_checker u_y2b_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

@@ tb/tb_yuyv_to_bgr_stream_converter_top.sv @@
// Self-checking bench for the YUYV to BGR stream converter: a pixel scoreboard
// with its own raster counters and BT.601 conversion, plus tasks that drive it.
// Depends on y2b_pkg and yuyv_to_bgr_stream_converter_top.
`timescale 1ns / 1ps

// Expected-pixel store: tracks geometry and raster position, predicts pixels
class bgr_scoreboard;
  localparam int unsigned COUNT_MAX = 4096;
  localparam int unsigned PRINT_CAP = 100;

  logic [12:0]        width_reg;
  logic [12:0]        height_reg;
  logic [12:0]        stride_reg;
  int unsigned        word_col;
  int unsigned        line_idx;
  y2b_pkg::out_item_t pixel_q[$];
  int unsigned        words_seen;
  int unsigned        errors;

  function new();
    width_reg     = y2b_pkg::RST_FRAME_WIDTH;
    height_reg    = y2b_pkg::RST_FRAME_HEIGHT;
    stride_reg    = y2b_pkg::RST_LINE_STRIDE;
    word_col      = 0;
    line_idx      = 0;
    words_seen    = 0;
    errors        = 0;
  endfunction

  function int unsigned pending();
    return pixel_q.size();
  endfunction

  // Track a register write; unknown indices leave everything alone
  function void write_reg(logic [1:0] idx, logic [12:0] data);
    case (idx)
      y2b_pkg::CFG_FRAME_WIDTH:  width_reg = data;
      y2b_pkg::CFG_FRAME_HEIGHT: height_reg = data;
      y2b_pkg::CFG_LINE_STRIDE:  stride_reg = data;
      default: ;
    endcase
  endfunction

  // Zero acts as one, large values saturate
  function int unsigned eff_reg(logic [12:0] v);
    if (v == '0) return 1;
    return (v > COUNT_MAX) ? COUNT_MAX : int'(v);
  endfunction

  function logic [7:0] sat8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // One BT.601 studio-range pixel with its position flags
  function y2b_pkg::out_item_t make_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v,
                                          int unsigned px, int unsigned width, bit last_row);
    y2b_pkg::out_item_t p;
    int c;
    int d;
    int e;
    c = int'(y) - 16;
    d = int'(u) - 128;
    e = int'(v) - 128;
    p.red       = sat8((298 * c + 409 * e + 128) >>> 8);
    p.green     = sat8((298 * c - 100 * d - 208 * e + 128) >>> 8);
    p.blue      = sat8((298 * c + 516 * d + 128) >>> 8);
    p.line_end  = (px == width - 1);
    p.frame_end = (px == width - 1) && last_row;
    p.run_last  = 1'b0;
    return p;
  endfunction

  // Predict the pixels of one accepted word, then advance the raster counters
  function void note_word(y2b_pkg::in_item_t w);
    int unsigned        stride;
    int unsigned        height;
    int unsigned        width;
    int unsigned        vis;
    int unsigned        px;
    bit                 last_row;
    y2b_pkg::out_item_t p;
    stride   = eff_reg(stride_reg);
    height   = eff_reg(height_reg);
    width    = eff_reg(width_reg);
    if (width > 2 * stride) width = 2 * stride;
    vis      = (width + 1) / 2;
    last_row = (line_idx == height - 1);
    words_seen++;

    if (word_col < vis) begin
      px = 2 * word_col;
      p = make_pixel(w.luma_first, w.chroma_blue, w.chroma_red, px, width, last_row);
      p.run_last = !(px + 1 < width);
      pixel_q.push_back(p);
      if (px + 1 < width) begin
        p = make_pixel(w.luma_second, w.chroma_blue, w.chroma_red, px + 1, width, last_row);
        p.run_last = 1'b1;
        pixel_q.push_back(p);
      end
    end

    if (word_col + 1 >= stride) begin
      word_col = 0;
      line_idx = (line_idx + 1 >= height) ? 0 : ((line_idx + 1) & 12'hFFF);
    end else begin
      word_col = (word_col + 1) & 12'hFFF;
    end
  endfunction

  task report(string msg);
    if (errors < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // Compare one output transfer against the oldest expected pixel
  task check_pixel(y2b_pkg::out_item_t got);
    y2b_pkg::out_item_t exp_px;
    if (pixel_q.size() == 0) begin
      report($sformatf("unexpected pixel %h", got));
      return;
    end
    exp_px = pixel_q.pop_front();
    if (got.blue != exp_px.blue)
      report($sformatf("blue got %0d want %0d", got.blue, exp_px.blue));
    if (got.green != exp_px.green)
      report($sformatf("green got %0d want %0d", got.green, exp_px.green));
    if (got.red != exp_px.red)
      report($sformatf("red got %0d want %0d", got.red, exp_px.red));
    if (got.line_end != exp_px.line_end)
      report($sformatf("line_end got %b want %b", got.line_end, exp_px.line_end));
    if (got.frame_end != exp_px.frame_end)
      report($sformatf("frame_end got %b want %b", got.frame_end, exp_px.frame_end));
    if (got.run_last != exp_px.run_last)
      report($sformatf("run_last got %b want %b", got.run_last, exp_px.run_last));
  endtask

  task leftover_check();
    if (pixel_q.size() != 0)
      report($sformatf("%0d expected pixels never arrived", pixel_q.size()));
  endtask
endclass

module tb_yuyv_to_bgr_stream_converter_top;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned RANDOM_WORDS  = 1600;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [1:0]  CFG_SPARE     = 2'd3;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  y2b_pkg::in_item_t              in_item_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  y2b_pkg::out_item_t             out_item_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [y2b_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [y2b_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  int unsigned   send_idle_pct = 14;
  int unsigned   recv_idle_pct = 62;
  int unsigned   cycle_count   = 0;
  bgr_scoreboard sb;

  yuyv_to_bgr_stream_converter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // Stall the pixel output at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Watch every transfer, feed the scoreboard and guard against a hang
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_word(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_pixel(out_item_o);
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic y2b_pkg::in_item_t mk_word(logic [7:0] y0, logic [7:0] u,
                                                logic [7:0] y1, logic [7:0] v);
    y2b_pkg::in_item_t w;
    w.luma_first  = y0;
    w.chroma_blue = u;
    w.luma_second = y1;
    w.chroma_red  = v;
    return w;
  endfunction

  // Offer one word, idling first at random, and hold it until the transfer
  task automatic send_word(y2b_pkg::in_item_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_word(mk_word(rand_byte(), rand_byte(), rand_byte(), rand_byte()));
  endtask

  // Drop valid, wait for every expected pixel, then let padding work finish
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(logic [12:0] width, logic [12:0] height, logic [12:0] stride);
    drain();
    write_reg(y2b_pkg::CFG_FRAME_WIDTH, width);
    write_reg(y2b_pkg::CFG_FRAME_HEIGHT, height);
    write_reg(y2b_pkg::CFG_LINE_STRIDE, stride);
  endtask

  // Pick a random geometry, mostly small frames, and stream a few frames of it
  task automatic random_phase();
    int unsigned w;
    int unsigned h;
    int unsigned s;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned s_eff;
    int unsigned vis;
    int unsigned words;
    case ($urandom_range(0, 9))
      0:       w = 0;
      1:       w = $urandom_range(4096, 8191);
      default: w = $urandom_range(1, 24);
    endcase
    case ($urandom_range(0, 9))
      0:       h = 0;
      1:       h = $urandom_range(4096, 8191);
      default: h = $urandom_range(1, 5);
    endcase
    w_eff = (w == 0) ? 1 : ((w > 4096) ? 4096 : w);
    vis   = (w_eff + 1) / 2;
    // Narrow strides cut the line; wide frames always get one
    if (vis > 24 || $urandom_range(0, 5) == 0) s = $urandom_range(0, (vis < 12) ? vis : 12);
    else s = vis + $urandom_range(0, 3);
    s_eff = (s == 0) ? 1 : s;
    h_eff = (h == 0 || h > 5) ? 2 : h;
    words = s_eff * h_eff * $urandom_range(1, 3) + $urandom_range(0, s_eff);
    if (words > 200) words = 200;
    // Stop at the word budget
    if (words > RANDOM_WORDS - sb.words_seen) words = RANDOM_WORDS - sb.words_seen;

    if (sb.words_seen < RANDOM_WORDS / 3) begin
      send_idle_pct = 14;
      recv_idle_pct = 62;
    end else if (sb.words_seen < 2 * RANDOM_WORDS / 3) begin
      send_idle_pct = 62;
      recv_idle_pct = 14;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end

    set_frame(13'(w), 13'(h), 13'(s));
    send_random(words);
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: field extremes, black, white and clipping on both ends
    send_word(mk_word(8'd0, 8'd0, 8'd0, 8'd0));
    send_word(mk_word(8'd255, 8'd255, 8'd255, 8'd255));
    send_word(mk_word(8'd16, 8'd128, 8'd235, 8'd128));
    send_word(mk_word(8'd255, 8'd0, 8'd0, 8'd255));
    send_word(mk_word(8'd0, 8'd255, 8'd255, 8'd0));
    send_word(mk_word(8'd235, 8'd240, 8'd16, 8'd16));
    send_word(mk_word(8'd81, 8'd90, 8'd145, 8'd240));

    // Odd width with padding, written mid-line so the column wraps past the stride
    set_frame(13'd3, 13'd2, 13'd3);
    send_random(10);

    // Zero registers act as one; a spare index must change nothing
    set_frame(13'd0, 13'd0, 13'd0);
    write_reg(CFG_SPARE, 13'h1FFF);
    send_random(3);

    // Saturated width and height, width cut to twice the stride
    set_frame(13'h1FFF, 13'h1FFF, 13'd2);
    send_random(4);

    while (sb.words_seen < RANDOM_WORDS) random_phase();

    drain();
    repeat (10) @(posedge clk_i);
    sb.leftover_check();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/y2b_pkg.sv
rtl/core/y2b_lane.sv
rtl/core/y2b_ctrl.sv
rtl/core/y2b_merge.sv
rtl/core/yuyv_to_bgr_stream_converter_top.sv
rtl/core/y2b_checker.sv
tb/tb_yuyv_to_bgr_stream_converter_top.sv
